// File: rtl/trplb_pkg.sv
// ----------------------------------------------------------------------------
// trplb_pkg
// Shared constants, codes and record types of the threshold load balancer.
// ----------------------------------------------------------------------------
`default_nettype none

package trplb_pkg;

  localparam int CPU_COUNT   = 16;
  localparam int QUEUE_DEPTH = 16;

  localparam int CW     = $clog2(CPU_COUNT);
  localparam int QW     = $clog2(QUEUE_DEPTH);
  localparam int QCW    = $clog2(QUEUE_DEPTH + 1);
  localparam int WORK_W = 16;
  localparam int QWW    = WORK_W + QCW;
  localparam int RW     = QWW + 1;
  localparam int TW     = RW + CW;
  localparam int CMPW   = TW + 2;
  localparam int TS_AW  = $clog2(CPU_COUNT * QUEUE_DEPTH);
  localparam int TIME_W = 32;

  localparam logic [15:0]       SAT_MAX     = 16'hFFFF;
  localparam logic [15:0]       LFSR_MASK   = 16'hB400;
  localparam logic [15:0]       SEED_RESET  = 16'd44257;
  localparam logic [3:0]        RETRY_RESET = 4'd4;
  localparam logic [TIME_W-1:0] TIME_MAX    = '1;

  localparam int CFG_IW = 1;
  localparam int CFG_DW = 16;
  localparam logic [CFG_IW-1:0] REG_RETRY_LIMIT = 1'b0;
  localparam logic [CFG_IW-1:0] REG_RANDOM_SEED = 1'b1;

  localparam logic [1:0] CMD_TICK     = 2'd0;
  localparam logic [1:0] CMD_ARRIVE   = 2'd1;
  localparam logic [1:0] CMD_COUNTERS = 2'd2;

  localparam logic [2:0] EV_PLACED   = 3'd0;
  localparam logic [2:0] EV_STARTED  = 3'd1;
  localparam logic [2:0] EV_FINISHED = 3'd2;
  localparam logic [2:0] EV_COUNTERS = 3'd3;
  localparam logic [2:0] EV_DROPPED  = 3'd4;

  typedef struct packed {
    logic [3:0]  origin;
    logic [15:0] id;
    logic [15:0] work;
  } task_t;

  typedef struct packed {
    logic [QW-1:0]     head;
    logic [QW-1:0]     tail;
    logic [QCW-1:0]    count;
    logic [QWW-1:0]    qwork;
    logic              busy;
    task_t             run;
    logic [TIME_W-1:0] start;
    logic [15:0]       sent;
    logic [15:0]       recv;
  } wrec_t;

  typedef struct packed {
    logic          rd_en;
    logic [CW-1:0] rd_addr;
    logic          wr_en;
    logic [CW-1:0] wr_addr;
  } wmem_req_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] task_id;
    logic [15:0] work_ticks;
    logic [3:0]  home_worker;
  } req_t;

  typedef struct packed {
    logic [2:0]        event_kind;
    logic [3:0]        worker;
    logic [15:0]       event_task;
    logic [3:0]        origin_worker;
    logic [15:0]       event_work;
    logic [TIME_W-1:0] time_stamp;
    logic [15:0]       probes_sent;
    logic [15:0]       probes_received;
    logic              last;
  } evt_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TK_RD,
    ST_TK_EV,
    ST_TK_ST,
    ST_TK_FLUSH,
    ST_AR_SUM,
    ST_AR_CLASS,
    ST_PR_RD,
    ST_PR_CHK,
    ST_HS_RD,
    ST_HS_WR,
    ST_TG_RD,
    ST_PLACE,
    ST_CN_RD,
    ST_CN_EM
  } state_t;

endpackage

`default_nettype wire

// File: rtl/trplb_if.sv
// ----------------------------------------------------------------------------
// trplb_if
// Valid/ready channels for requests and events of the load balancer.
// ----------------------------------------------------------------------------
`default_nettype none

interface trplb_req_if import trplb_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface trplb_evt_if import trplb_pkg::*; ();
  logic valid;
  logic ready;
  evt_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/threshold_random_probe_load_balancer_core.sv
// ----------------------------------------------------------------------------
// threshold_random_probe_load_balancer_core
// Task dispatcher for sixteen workers with threshold tests and random probes.
//
// Requests enter on req (valid/ready); each request is one transaction that
// is a time tick, a task arrival or a read of one worker's probe counters.
// Events leave on evt, one transaction each, with last set on the final
// event of a request. A new request is taken only once all events of the
// previous one have been handed to the output register.
// Steps of each request once accepted: a tick reads each worker's record,
// emits a finish event if its task has ended and starts a queued task if
// the worker is free, then flushes the last event; an arrival sweeps all
// records for the mean load, classifies, reads and checks one worker per
// probe and updates the sender when probes run, then reads the target and
// places the task; a counter read reads the record and emits it. Each step
// makes at most one access of the worker record memory.
// After reset the block clears the worker records in turn and takes no
// request meanwhile; configuration writes are accepted throughout.
// When the receiver stalls, the event stays in the output register and the
// block holds in the state that produces the next event.
// ----------------------------------------------------------------------------
`default_nettype none

module threshold_random_probe_load_balancer_core import trplb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  trplb_req_if.sink         req,
  trplb_evt_if.source       evt,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  state_t            state;
  state_t            state_next;
  logic [CW:0]       wcnt;
  logic [15:0]       cur_id;
  logic [15:0]       cur_work;
  logic [CW-1:0]     home;
  logic [CW-1:0]     target;
  logic [TW-1:0]     total;
  logic [RW-1:0]     rh;
  logic              seek_over;
  logic [3:0]        probes;
  logic [3:0]        retry_limit;
  logic [15:0]       lfsr;
  logic [TIME_W-1:0] now;
  logic              pend_valid;
  evt_t              pend;
  evt_t              pend_fin;
  logic              out_valid;
  evt_t              out_data;

  task_t ts_mem [CPU_COUNT * QUEUE_DEPTH];
  task_t ts_rdata;
  logic  ts_we;
  logic  ts_re;
  logic [TS_AW-1:0] ts_waddr;
  logic [TS_AW-1:0] ts_raddr;

  wmem_req_t     wm_req;
  wrec_t         wm_wdata;
  wrec_t         rd;
  logic [RW-1:0] rem;

  logic [CW-1:0]   widx;
  logic            last_w;
  logic [15:0]     lfsr_next;
  logic [TIME_W:0] run_end;
  logic            fin;
  logic            start_q;
  logic            ev_go;
  logic            out_free;
  logic            push_ok;
  logic [CMPW-1:0] rem_n;
  logic [CMPW-1:0] rh_n;
  logic [CMPW-1:0] tot;
  logic            under_rem;
  logic            notover_rem;
  logic            under_rh;
  logic            notover_rh;
  logic            seek_ok;
  logic [16:0]     sent_sum;
  logic [15:0]     sent_new;
  logic [15:0]     recv_new;
  logic            full;
  logic [QW-1:0]   next_head;
  logic [QW-1:0]   next_tail;
  task_t           new_task;
  evt_t            ev_new;
  logic            push_en;
  logic            direct_en;
  logic            flush_en;

  trplb_wmem u_wmem (
    .clk   (clk),
    .req   (wm_req),
    .wdata (wm_wdata),
    .now   (now),
    .rdata (rd),
    .rem   (rem)
  );

  always_comb begin
    widx        = wcnt[CW-1:0];
    last_w      = (widx == CW'(CPU_COUNT - 1));
    lfsr_next   = {1'b0, lfsr[15:1]} ^ (lfsr[0] ? LFSR_MASK : 16'h0000);
    run_end     = {1'b0, rd.start} + (TIME_W + 1)'(rd.run.work);
    fin         = rd.busy && (run_end < {1'b0, now});
    start_q     = (!rd.busy || fin) && (rd.count != '0);
    out_free    = !out_valid || evt.ready;
    push_ok     = !pend_valid || out_free;
    ev_go       = !(fin && !push_ok);
    rem_n       = CMPW'(rem) * CMPW'(CPU_COUNT);
    rh_n        = CMPW'(rh) * CMPW'(CPU_COUNT);
    tot         = CMPW'(total);
    under_rem   = (rem_n << 1) < tot;
    notover_rem = rem_n <= (tot << 1);
    under_rh    = (rh_n << 1) < tot;
    notover_rh  = rh_n <= (tot << 1);
    seek_ok     = seek_over ? notover_rem : under_rem;
    sent_sum    = 17'(rd.sent) + 17'(probes);
    sent_new    = (sent_sum > 17'(SAT_MAX)) ? SAT_MAX : sent_sum[15:0];
    recv_new    = (rd.recv == SAT_MAX) ? rd.recv : rd.recv + 16'd1;
    full        = (rd.count == QCW'(QUEUE_DEPTH));
    next_head   = (rd.head == QW'(QUEUE_DEPTH - 1)) ? '0 : rd.head + 1'b1;
    next_tail   = (rd.tail == QW'(QUEUE_DEPTH - 1)) ? '0 : rd.tail + 1'b1;
    new_task    = '{origin: 4'(home), id: cur_id, work: cur_work};
    pend_fin      = pend;
    pend_fin.last = 1'b1;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (last_w) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req.valid) begin
          case (req.data.cmd)
            CMD_TICK:     state_next = ST_TK_RD;
            CMD_ARRIVE:   state_next = ST_AR_SUM;
            CMD_COUNTERS: state_next = ST_CN_RD;
            default:      state_next = ST_IDLE;
          endcase
        end
      end
      ST_TK_RD: state_next = ST_TK_EV;
      ST_TK_EV: begin
        if (ev_go) begin
          if (start_q) begin
            state_next = ST_TK_ST;
          end else begin
            state_next = last_w ? ST_TK_FLUSH : ST_TK_RD;
          end
        end
      end
      ST_TK_ST: begin
        if (push_ok) begin
          state_next = last_w ? ST_TK_FLUSH : ST_TK_RD;
        end
      end
      ST_TK_FLUSH: begin
        if (!pend_valid || out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_AR_SUM: begin
        if (wcnt == (CW + 1)'(CPU_COUNT)) begin
          state_next = ST_AR_CLASS;
        end
      end
      ST_AR_CLASS: begin
        state_next = (under_rh || retry_limit == '0) ? ST_TG_RD : ST_PR_RD;
      end
      ST_PR_RD: state_next = ST_PR_CHK;
      ST_PR_CHK: begin
        state_next = (seek_ok || probes == retry_limit) ? ST_HS_RD : ST_PR_RD;
      end
      ST_HS_RD: state_next = ST_HS_WR;
      ST_HS_WR: state_next = ST_TG_RD;
      ST_TG_RD: state_next = ST_PLACE;
      ST_PLACE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_CN_RD: state_next = ST_CN_EM;
      ST_CN_EM: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    wm_req    = '0;
    wm_wdata  = rd;
    ts_we     = 1'b0;
    ts_re     = 1'b0;
    ts_waddr  = TS_AW'(TS_AW'(target) * TS_AW'(QUEUE_DEPTH) + TS_AW'(rd.tail));
    ts_raddr  = TS_AW'(TS_AW'(widx) * TS_AW'(QUEUE_DEPTH) + TS_AW'(rd.head));
    push_en   = 1'b0;
    direct_en = 1'b0;
    flush_en  = 1'b0;
    ev_new    = '0;
    ev_new.time_stamp = now;
    case (state)
      ST_CLEAR: begin
        wm_req.wr_en   = 1'b1;
        wm_req.wr_addr = widx;
        wm_wdata       = '0;
      end
      ST_TK_RD: begin
        wm_req.rd_en   = 1'b1;
        wm_req.rd_addr = widx;
      end
      ST_TK_EV: begin
        ev_new.event_kind    = EV_FINISHED;
        ev_new.worker        = 4'(widx);
        ev_new.event_task    = rd.run.id;
        ev_new.origin_worker = rd.run.origin;
        ev_new.event_work    = rd.run.work;
        wm_wdata.busy        = rd.busy && !fin;
        if (ev_go) begin
          push_en        = fin;
          ts_re          = start_q;
          wm_req.wr_en   = !start_q;
          wm_req.wr_addr = widx;
        end
      end
      ST_TK_ST: begin
        ev_new.event_kind    = EV_STARTED;
        ev_new.worker        = 4'(widx);
        ev_new.event_task    = ts_rdata.id;
        ev_new.origin_worker = ts_rdata.origin;
        ev_new.event_work    = ts_rdata.work;
        wm_wdata.head        = next_head;
        wm_wdata.count       = rd.count - 1'b1;
        wm_wdata.qwork       = rd.qwork - QWW'(ts_rdata.work);
        wm_wdata.busy        = 1'b1;
        wm_wdata.run         = ts_rdata;
        wm_wdata.start       = now;
        if (push_ok) begin
          push_en        = 1'b1;
          wm_req.wr_en   = 1'b1;
          wm_req.wr_addr = widx;
        end
      end
      ST_TK_FLUSH: flush_en = pend_valid && out_free;
      ST_AR_SUM: begin
        wm_req.rd_en   = (wcnt < (CW + 1)'(CPU_COUNT));
        wm_req.rd_addr = widx;
      end
      ST_PR_RD: begin
        wm_req.rd_en   = 1'b1;
        wm_req.rd_addr = lfsr_next[CW-1:0];
      end
      ST_PR_CHK: begin
        wm_req.wr_en   = 1'b1;
        wm_req.wr_addr = target;
        wm_wdata.recv  = recv_new;
      end
      ST_HS_RD: begin
        wm_req.rd_en   = 1'b1;
        wm_req.rd_addr = home;
      end
      ST_HS_WR: begin
        wm_req.wr_en   = 1'b1;
        wm_req.wr_addr = home;
        wm_wdata.sent  = sent_new;
      end
      ST_TG_RD: begin
        wm_req.rd_en   = 1'b1;
        wm_req.rd_addr = target;
      end
      ST_PLACE: begin
        ev_new.event_kind    = full ? EV_DROPPED : EV_PLACED;
        ev_new.worker        = 4'(target);
        ev_new.event_task    = cur_id;
        ev_new.origin_worker = 4'(home);
        ev_new.event_work    = cur_work;
        ev_new.last          = 1'b1;
        wm_wdata.tail        = next_tail;
        wm_wdata.count       = rd.count + 1'b1;
        wm_wdata.qwork       = rd.qwork + QWW'(cur_work);
        if (out_free) begin
          direct_en      = 1'b1;
          ts_we          = !full;
          wm_req.wr_en   = !full;
          wm_req.wr_addr = target;
        end
      end
      ST_CN_RD: begin
        wm_req.rd_en   = 1'b1;
        wm_req.rd_addr = home;
      end
      ST_CN_EM: begin
        ev_new.event_kind      = EV_COUNTERS;
        ev_new.worker          = 4'(home);
        ev_new.probes_sent     = rd.sent;
        ev_new.probes_received = rd.recv;
        ev_new.last            = 1'b1;
        direct_en              = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ts_we) begin
      ts_mem[ts_waddr] <= new_task;
    end
    if (ts_re) begin
      ts_rdata <= ts_mem[ts_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      wcnt        <= '0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
      lfsr        <= SEED_RESET;
      retry_limit <= RETRY_RESET;
      now         <= '0;
      probes      <= '0;
    end else begin
      state <= state_next;

      if (direct_en) begin
        out_data  <= ev_new;
        out_valid <= 1'b1;
      end else if (push_en && pend_valid) begin
        out_data  <= pend;
        out_valid <= 1'b1;
      end else if (flush_en) begin
        out_data  <= pend_fin;
        out_valid <= 1'b1;
      end else if (evt.ready) begin
        out_valid <= 1'b0;
      end
      if (push_en) begin
        pend       <= ev_new;
        pend_valid <= 1'b1;
      end else if (flush_en) begin
        pend_valid <= 1'b0;
      end

      case (state)
        ST_CLEAR: wcnt <= last_w ? '0 : wcnt + 1'b1;
        ST_IDLE: begin
          if (req.valid) begin
            cur_id   <= req.data.task_id;
            cur_work <= req.data.work_ticks;
            home     <= req.data.home_worker[CW-1:0];
            wcnt     <= '0;
            total    <= '0;
            probes   <= '0;
            if (req.data.cmd == CMD_TICK && now != TIME_MAX) begin
              now <= now + 1'b1;
            end
          end
        end
        ST_TK_EV: begin
          if (ev_go && !start_q) begin
            wcnt <= wcnt + 1'b1;
          end
        end
        ST_TK_ST: begin
          if (push_ok) begin
            wcnt <= wcnt + 1'b1;
          end
        end
        ST_AR_SUM: begin
          wcnt <= wcnt + 1'b1;
          if (wcnt != '0) begin
            total <= total + TW'(rem);
            if (CW'(wcnt - 1'b1) == home) begin
              rh <= rem;
            end
          end
        end
        ST_AR_CLASS: begin
          seek_over <= !notover_rh;
          target    <= home;
        end
        ST_PR_RD: begin
          lfsr   <= lfsr_next;
          target <= lfsr_next[CW-1:0];
          probes <= probes + 1'b1;
        end
        ST_PR_CHK: begin
          if (!seek_ok && probes == retry_limit) begin
            target <= home;
          end
        end
        default: begin
        end
      endcase

      if (cfg_we) begin
        case (cfg_index)
          REG_RETRY_LIMIT: retry_limit <= cfg_data[3:0];
          REG_RANDOM_SEED: lfsr <= (cfg_data == '0) ? 16'd1 : cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  assign req.ready = (state == ST_IDLE);
  assign evt.valid = out_valid;
  assign evt.data  = out_data;

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend_valid)
    else $error("pending event left at idle");

  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PR_CHK) |-> (probes != '0 && probes <= retry_limit))
    else $error("probe count out of range");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PLACE || state == ST_CN_EM) |-> !pend_valid)
    else $error("pending event during single-result request");

endmodule

`default_nettype wire

// File: rtl/trplb_wmem.sv
// ----------------------------------------------------------------------------
// trplb_wmem
// Worker record memory with registered read and remaining-work calculation.
// ----------------------------------------------------------------------------
`default_nettype none

module trplb_wmem import trplb_pkg::*; (
  input  logic              clk,
  input  wmem_req_t         req,
  input  wrec_t             wdata,
  input  logic [TIME_W-1:0] now,
  output wrec_t             rdata,
  output logic [RW-1:0]     rem
);

  wrec_t mem [CPU_COUNT];
  logic [TIME_W:0] run_end;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= wdata;
    end
    if (req.rd_en) begin
      rdata <= mem[req.rd_addr];
    end
  end

  always_comb begin
    run_end = {1'b0, rdata.start} + (TIME_W + 1)'(rdata.run.work);
    if (rdata.busy && (run_end > {1'b0, now})) begin
      rem = RW'(rdata.qwork) + RW'(run_end - {1'b0, now});
    end else begin
      rem = RW'(rdata.qwork);
    end
  end

endmodule

`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the threshold random-probe load balancer.
//
// Sends ticks, arrivals, counter reads and unused commands over the request
// channel, with random gaps on both sides. A software copy of the dispatcher
// (queues, running tasks, mean-load thresholds, probe LFSR and saturating
// counters) predicts every event, and each event transaction is compared
// field by field. Directed tests cover field extremes, a full queue and seed
// handling. Random phases follow under several register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import trplb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT  = 1000000;
  localparam int         SETTLE_WAIT  = 80;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;

  trplb_req_if req_ch ();
  trplb_evt_if evt_ch ();

  threshold_random_probe_load_balancer_core u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .evt       (evt_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // dispatcher mirror
  task_t       slot_mem [CPU_COUNT*QUEUE_DEPTH];
  int unsigned q_head   [CPU_COUNT];
  int unsigned q_tail   [CPU_COUNT];
  int unsigned q_cnt    [CPU_COUNT];
  int unsigned q_work   [CPU_COUNT];
  bit          w_busy   [CPU_COUNT];
  task_t       run_task [CPU_COUNT];
  logic [31:0] run_start[CPU_COUNT];
  int unsigned sent_cnt [CPU_COUNT];
  int unsigned recv_cnt [CPU_COUNT];
  logic [15:0] probe_lfsr;
  logic [3:0]  retry_limit;
  logic [31:0] now_ticks;

  evt_t pending_events[$];
  int   errors;
  int   items_sent;
  int   events_seen;
  int   drops_seen;
  int   cycles;
  bit   req_burst;
  bit   evt_burst;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("%0t: timeout with %0d events outstanding", $time, pending_events.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic void mirror_reset();
    for (int w = 0; w < CPU_COUNT; w++) begin
      q_head[w] = 0;
      q_tail[w] = 0;
      q_cnt[w] = 0;
      q_work[w] = 0;
      w_busy[w] = 1'b0;
      sent_cnt[w] = 0;
      recv_cnt[w] = 0;
    end
    now_ticks = '0;
    retry_limit = RETRY_RESET;
    probe_lfsr = SEED_RESET;
  endfunction

  function automatic longint unsigned backlog(int w);
    longint unsigned r;
    longint unsigned fin;
    r = q_work[w];
    if (w_busy[w]) begin
      fin = longint'(run_start[w]) + run_task[w].work;
      if (fin > now_ticks) r += fin - now_ticks;
    end
    return r;
  endfunction

  function automatic int step_probe(int home);
    int t;
    bit lsb;
    lsb = probe_lfsr[0];
    probe_lfsr = probe_lfsr >> 1;
    if (lsb) probe_lfsr ^= LFSR_MASK;
    t = probe_lfsr % CPU_COUNT;
    if (sent_cnt[home] < 65535) sent_cnt[home]++;
    if (recv_cnt[t] < 65535) recv_cnt[t]++;
    return t;
  endfunction

  function automatic void push_event(logic [2:0] kind, int w, task_t t, int ps, int pr);
    evt_t e;
    e.event_kind = kind;
    e.worker = w[3:0];
    e.event_task = t.id;
    e.origin_worker = t.origin;
    e.event_work = t.work;
    e.time_stamp = now_ticks;
    e.probes_sent = ps[15:0];
    e.probes_received = pr[15:0];
    e.last = 1'b0;
    pending_events.insert(pending_events.size(), e);
  endfunction

  function automatic void predict_events(req_t r);
    int n_prior;
    int home;
    int target;
    int t;
    longint unsigned total;
    longint unsigned rh;
    longint unsigned fin;
    task_t tk;
    task_t none;
    n_prior = pending_events.size();
    home = r.home_worker % CPU_COUNT;
    none = '0;
    case (r.cmd)
      CMD_TICK: begin
        if (now_ticks != TIME_MAX) now_ticks++;
        for (int w = 0; w < CPU_COUNT; w++) begin
          if (w_busy[w]) begin
            fin = longint'(run_start[w]) + run_task[w].work;
            if (fin < now_ticks) begin
              push_event(EV_FINISHED, w, run_task[w], 0, 0);
              w_busy[w] = 1'b0;
            end
          end
          if (!w_busy[w] && q_cnt[w] != 0) begin
            tk = slot_mem[w*QUEUE_DEPTH + q_head[w]];
            q_head[w] = (q_head[w] + 1) % QUEUE_DEPTH;
            q_cnt[w]--;
            q_work[w] -= tk.work;
            run_task[w] = tk;
            run_start[w] = now_ticks;
            w_busy[w] = 1'b1;
            push_event(EV_STARTED, w, tk, 0, 0);
          end
        end
      end
      CMD_ARRIVE: begin
        tk.work = r.work_ticks;
        tk.id = r.task_id;
        tk.origin = r.home_worker;
        total = 0;
        for (int w = 0; w < CPU_COUNT; w++) total += backlog(w);
        rh = backlog(home);
        target = home;
        if (2 * rh * CPU_COUNT < total) begin
          target = home;
        end else if (rh * CPU_COUNT <= 2 * total) begin
          for (int i = 0; i < retry_limit; i++) begin
            t = step_probe(home);
            if (2 * backlog(t) * CPU_COUNT < total) begin
              target = t;
              break;
            end
          end
        end else begin
          for (int i = 0; i < retry_limit; i++) begin
            t = step_probe(home);
            if (backlog(t) * CPU_COUNT <= 2 * total) begin
              target = t;
              break;
            end
          end
        end
        if (q_cnt[target] >= QUEUE_DEPTH) begin
          push_event(EV_DROPPED, target, tk, 0, 0);
        end else begin
          slot_mem[target*QUEUE_DEPTH + q_tail[target]] = tk;
          q_tail[target] = (q_tail[target] + 1) % QUEUE_DEPTH;
          q_cnt[target]++;
          q_work[target] += tk.work;
          push_event(EV_PLACED, target, tk, 0, 0);
        end
      end
      CMD_COUNTERS: begin
        push_event(EV_COUNTERS, home, none, sent_cnt[home], recv_cnt[home]);
      end
      default: begin
      end
    endcase
    if (pending_events.size() > n_prior) pending_events[$].last = 1'b1;
  endfunction

  task automatic send_request(logic [1:0] cmd, logic [15:0] id, logic [15:0] work,
                              logic [3:0] home);
    req_t r;
    int gap;
    r.cmd = cmd;
    r.task_id = id;
    r.work_ticks = work;
    r.home_worker = home;
    gap = req_burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    predict_events(r);
    items_sent++;
  endtask

  // hold off until every expected event is out and the block is idle
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_RETRY_LIMIT) begin
      retry_limit = value[3:0];
    end else begin
      probe_lfsr = (value == 16'd0) ? 16'd1 : value;
    end
  endtask

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  initial begin
    int stall;
    evt_t e;
    evt_t got;
    forever begin
      stall = evt_burst ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        evt_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      evt_ch.ready <= 1'b1;
      do @(posedge clk); while (evt_ch.valid !== 1'b1);
      got = evt_ch.data;
      events_seen++;
      if (got.event_kind == EV_DROPPED) drops_seen++;
      if (pending_events.size() == 0) begin
        errors++;
        $display("%0t: unexpected event, expected none, actual kind %0d worker %0d",
                 $time, got.event_kind, got.worker);
      end else begin
        e = pending_events.pop_front();
        check_field("event_kind", e.event_kind, got.event_kind);
        check_field("worker", e.worker, got.worker);
        check_field("event_task", e.event_task, got.event_task);
        check_field("origin_worker", e.origin_worker, got.origin_worker);
        check_field("event_work", e.event_work, got.event_work);
        check_field("time_stamp", e.time_stamp, got.time_stamp);
        check_field("probes_sent", e.probes_sent, got.probes_sent);
        check_field("probes_received", e.probes_received, got.probes_received);
        check_field("last", e.last, got.last);
      end
    end
  end

  task automatic test_idle_commands();
    send_request(CMD_COUNTERS, 16'hFFFF, 16'hFFFF, 4'd0);
    send_request(CMD_COUNTERS, 16'h0, 16'h0, 4'd15);
    send_request(CMD_TICK, 16'h0, 16'h0, 4'd0);
    send_request(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 4'd15);
    settle();
  endtask

  task automatic test_extremes();
    send_request(CMD_ARRIVE, 16'h0000, 16'h0000, 4'd0);
    send_request(CMD_ARRIVE, 16'hFFFF, 16'd3, 4'd15);
    send_request(CMD_ARRIVE, 16'h5A5A, 16'hFFFF, 4'd7);
    send_request(CMD_ARRIVE, 16'hA5A5, 16'd1, 4'd7);
    send_request(CMD_ARRIVE, 16'h1234, 16'd2, 4'd7);
    for (int i = 0; i < 5; i++) send_request(CMD_TICK, 16'h0, 16'h0, 4'd0);
    send_request(CMD_COUNTERS, 16'h0, 16'h0, 4'd7);
    settle();
  endtask

  task automatic test_queue_full();
    write_reg(REG_RETRY_LIMIT, 16'd0);
    req_burst = 1'b1;
    for (int i = 0; i < QUEUE_DEPTH + 2; i++) send_request(CMD_ARRIVE, 16'(i), 16'd1, 4'd3);
    req_burst = 1'b0;
    send_request(CMD_COUNTERS, 16'h0, 16'h0, 4'd3);
    for (int i = 0; i < 3; i++) send_request(CMD_TICK, 16'h0, 16'h0, 4'd0);
    settle();
  endtask

  task automatic test_seed();
    write_reg(REG_RANDOM_SEED, 16'd0);
    write_reg(REG_RETRY_LIMIT, 16'd15);
    for (int i = 0; i < 4; i++) send_request(CMD_ARRIVE, 16'(100 + i), 16'd4, 4'd9);
    settle();
    write_reg(REG_RANDOM_SEED, 16'hFFFF);
    for (int i = 0; i < 4; i++) send_request(CMD_ARRIVE, 16'(200 + i), 16'd6, 4'd9);
    send_request(CMD_COUNTERS, 16'h0, 16'h0, 4'd9);
    settle();
  endtask

  task automatic test_random_traffic();
    int pick;
    logic [15:0] work;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_RETRY_LIMIT, 16'd0);
          write_reg(REG_RANDOM_SEED, 16'($urandom_range(1, 65535)));
        end
        1: begin
          write_reg(REG_RETRY_LIMIT, 16'd15);
          write_reg(REG_RANDOM_SEED, 16'd1);
        end
        2: begin
          write_reg(REG_RETRY_LIMIT, 16'($urandom_range(0, 15)));
          write_reg(REG_RANDOM_SEED, 16'($urandom_range(1, 65535)));
        end
        default: begin
          write_reg(REG_RETRY_LIMIT, 16'd4);
          write_reg(REG_RANDOM_SEED, 16'd65535);
        end
      endcase
      req_burst = (phase == 2);
      evt_burst = (phase == 1);
      for (int i = 0; i < 40; i++) begin
        pick = $urandom_range(0, 99);
        work = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
        if (pick < 45) begin
          send_request(CMD_ARRIVE, 16'($urandom), work, 4'($urandom));
        end else if (pick < 88) begin
          send_request(CMD_TICK, 16'($urandom), 16'($urandom), 4'($urandom));
        end else if (pick < 96) begin
          send_request(CMD_COUNTERS, 16'($urandom), 16'($urandom), 4'($urandom));
        end else begin
          send_request(CMD_UNUSED, 16'($urandom), 16'($urandom), 4'($urandom));
        end
      end
      settle();
    end
    req_burst = 1'b0;
    evt_burst = 1'b0;
  endtask

  initial begin
    errors = 0;
    items_sent = 0;
    events_seen = 0;
    drops_seen = 0;
    req_burst = 1'b0;
    evt_burst = 1'b0;
    mirror_reset();
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    req_ch.valid <= 1'b0;
    req_ch.data <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_idle_commands();
    test_extremes();
    test_queue_full();
    test_seed();
    test_random_traffic();

    if (pending_events.size() != 0) begin
      errors++;
      $display("%0t: %0d expected events never arrived", $time, pending_events.size());
    end
    $display("Covered %0d requests and %0d events (%0d drops) at tick %0d.",
             items_sent, events_seen, drops_seen, now_ticks);
    $display("Retry limits 0, 4, 15 and random; seeds 0, 1, 65535 and random.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
rtl/trplb_pkg.sv
rtl/trplb_if.sv
rtl/trplb_wmem.sv
rtl/threshold_random_probe_load_balancer_core.sv
tb/tb.sv
